// ===== rtl/awbg_pkg.sv =====
`default_nettype none
package awbg_pkg;

    localparam int RATIO_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;

    // restoring divider geometry
    localparam int NUM_W      = 28;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = NUM_W / DIV_BITS;

    // gain sets buffered between the divider pipeline and the write sequencer
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_RED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_BLUE = 2'd1;

    localparam logic [RATIO_W-1:0] UNITY_GAIN   = 16'h0100;
    localparam logic [RATIO_W-1:0] RATIO_ONE    = 16'd512;
    localparam logic [NUM_W-1:0]   NUM_GAIN_ONE = NUM_W'(32'h0002_0000);

    localparam logic [RATIO_W-1:0] ADDR_GROUP_HOLD = 16'h3FF9;
    localparam logic [RATIO_W-1:0] ADDR_RED        = 16'h0210;
    localparam logic [RATIO_W-1:0] ADDR_BLUE       = 16'h0212;
    localparam logic [RATIO_W-1:0] ADDR_GREEN1     = 16'h020E;
    localparam logic [RATIO_W-1:0] ADDR_GREEN2     = 16'h0214;

    localparam int BEAT_W = 4;
    localparam logic [BEAT_W-1:0] BEAT_HOLD     = 4'd0;
    localparam logic [BEAT_W-1:0] BEAT_RED_HI   = 4'd1;
    localparam logic [BEAT_W-1:0] BEAT_RED_LO   = 4'd2;
    localparam logic [BEAT_W-1:0] BEAT_BLUE_HI  = 4'd3;
    localparam logic [BEAT_W-1:0] BEAT_BLUE_LO  = 4'd4;
    localparam logic [BEAT_W-1:0] BEAT_GRN1_HI  = 4'd5;
    localparam logic [BEAT_W-1:0] BEAT_GRN1_LO  = 4'd6;
    localparam logic [BEAT_W-1:0] BEAT_GRN2_HI  = 4'd7;
    localparam logic [BEAT_W-1:0] BEAT_GRN2_LO  = 4'd8;

    typedef struct packed {
        logic               err;
        logic [RATIO_W-1:0] red_gain;
        logic [RATIO_W-1:0] blue_gain;
        logic [RATIO_W-1:0] green_gain;
    } t_gain_set;

endpackage
`default_nettype wire

// ===== rtl/awbg_div.sv =====
`default_nettype none
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// Quotient is returned modulo 2^16.
module awbg_div (
    input  wire logic                              i_clk,
    input  wire logic [awbg_pkg::NUM_W-1:0]        i_num,
    input  wire logic [awbg_pkg::RATIO_W-1:0]      i_den,
    output logic      [awbg_pkg::RATIO_W-1:0]      o_quo
);

    logic [awbg_pkg::RATIO_W-1:0] r_rem [awbg_pkg::DIV_STAGES];
    logic [awbg_pkg::NUM_W-1:0]   r_num [awbg_pkg::DIV_STAGES];
    logic [awbg_pkg::RATIO_W-1:0] r_quo [awbg_pkg::DIV_STAGES];
    logic [awbg_pkg::RATIO_W-1:0] r_den [awbg_pkg::DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < awbg_pkg::DIV_STAGES; s++) begin : g_stage
            logic [awbg_pkg::RATIO_W-1:0] rem_in, quo_in, den_in;
            logic [awbg_pkg::NUM_W-1:0]   num_in;
            logic [awbg_pkg::RATIO_W-1:0] n_rem, n_quo;
            logic [awbg_pkg::NUM_W-1:0]   n_num;

            if (s == 0) begin : g_first
                assign rem_in = '0;
                assign quo_in = '0;
                assign num_in = i_num;
                assign den_in = i_den;
            end else begin : g_next
                assign rem_in = r_rem[s-1];
                assign quo_in = r_quo[s-1];
                assign num_in = r_num[s-1];
                assign den_in = r_den[s-1];
            end

            always_comb begin
                logic [awbg_pkg::RATIO_W:0] t;
                logic                       qb;
                n_rem = rem_in;
                n_quo = quo_in;
                n_num = num_in;
                for (int b = 0; b < awbg_pkg::DIV_BITS; b++) begin
                    t     = {n_rem, n_num[awbg_pkg::NUM_W-1]};
                    n_num = {n_num[awbg_pkg::NUM_W-2:0], 1'b0};
                    qb    = (t >= {1'b0, den_in});
                    if (qb) begin
                        t = t - {1'b0, den_in};
                    end
                    n_rem = t[awbg_pkg::RATIO_W-1:0];
                    n_quo = {n_quo[awbg_pkg::RATIO_W-2:0], qb};
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_num[s] <= n_num;
                r_den[s] <= den_in;
            end
        end
    endgenerate

    assign o_quo = r_quo[awbg_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/awbg_ser.sv =====
`default_nettype none
// Gain-set queue and register write sequencer: one beat per cycle while a gain set is active.
module awbg_ser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire awbg_pkg::t_gain_set             i_set,
    output logic                                 o_done,
    output logic                                 o_strobe,
    output logic [awbg_pkg::RATIO_W-1:0]         o_reg_address,
    output logic [awbg_pkg::BYTE_W-1:0]          o_reg_data,
    output logic                                 o_error,
    output logic                                 o_last
);

    awbg_pkg::t_gain_set             r_mem [awbg_pkg::FIFO_DEPTH];
    logic [awbg_pkg::FIFO_AW-1:0]    r_wr, r_rd;
    logic [awbg_pkg::CNT_W-1:0]      r_fill;
    logic                            r_active;
    logic [awbg_pkg::BEAT_W-1:0]     r_beat;
    awbg_pkg::t_gain_set             r_cur;

    logic                            r_strobe, r_error, r_last;
    logic [awbg_pkg::RATIO_W-1:0]    r_addr;
    logic [awbg_pkg::BYTE_W-1:0]     r_data;

    logic                            fin;
    logic                            pop;
    logic [awbg_pkg::RATIO_W-1:0]    n_addr;
    logic [awbg_pkg::BYTE_W-1:0]     n_data;

    assign fin = r_active && (r_cur.err || r_beat == awbg_pkg::BEAT_GRN2_LO);
    assign pop = (r_fill != '0) && (!r_active || fin);

    always_comb begin
        n_addr = '0;
        n_data = '0;
        case (r_beat)
            awbg_pkg::BEAT_HOLD: begin
                n_addr = awbg_pkg::ADDR_GROUP_HOLD;
            end
            awbg_pkg::BEAT_RED_HI: begin
                n_addr = awbg_pkg::ADDR_RED;
                n_data = r_cur.red_gain[15:8];
            end
            awbg_pkg::BEAT_RED_LO: begin
                n_addr = awbg_pkg::ADDR_RED + 16'd1;
                n_data = r_cur.red_gain[7:0];
            end
            awbg_pkg::BEAT_BLUE_HI: begin
                n_addr = awbg_pkg::ADDR_BLUE;
                n_data = r_cur.blue_gain[15:8];
            end
            awbg_pkg::BEAT_BLUE_LO: begin
                n_addr = awbg_pkg::ADDR_BLUE + 16'd1;
                n_data = r_cur.blue_gain[7:0];
            end
            awbg_pkg::BEAT_GRN1_HI: begin
                n_addr = awbg_pkg::ADDR_GREEN1;
                n_data = r_cur.green_gain[15:8];
            end
            awbg_pkg::BEAT_GRN1_LO: begin
                n_addr = awbg_pkg::ADDR_GREEN1 + 16'd1;
                n_data = r_cur.green_gain[7:0];
            end
            awbg_pkg::BEAT_GRN2_HI: begin
                n_addr = awbg_pkg::ADDR_GREEN2;
                n_data = r_cur.green_gain[15:8];
            end
            awbg_pkg::BEAT_GRN2_LO: begin
                n_addr = awbg_pkg::ADDR_GREEN2 + 16'd1;
                n_data = r_cur.green_gain[7:0];
            end
            default: begin
                n_addr = '0;
                n_data = '0;
            end
        endcase
        // error beat carries zero address and data
        if (r_cur.err) begin
            n_addr = '0;
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_set;
        end
        if (pop) begin
            r_cur <= r_mem[r_rd];
        end
        r_addr <= n_addr;
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_fill   <= '0;
            r_active <= 1'b0;
            r_beat   <= '0;
            r_strobe <= 1'b0;
            r_error  <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill <= r_fill + CNT_INC(i_push) - CNT_INC(pop);
            if (pop) begin
                r_active <= 1'b1;
                r_beat   <= awbg_pkg::BEAT_HOLD;
            end else if (fin) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_beat <= r_beat + 1'b1;
            end
            r_strobe <= r_active;
            r_error  <= r_active && r_cur.err;
            r_last   <= fin;
        end
    end

    function automatic logic [awbg_pkg::CNT_W-1:0] CNT_INC(input logic b);
        CNT_INC = {{(awbg_pkg::CNT_W-1){1'b0}}, b};
    endfunction

    assign o_done        = fin;
    assign o_strobe      = r_strobe;
    assign o_reg_address = r_addr;
    assign o_reg_data    = r_data;
    assign o_error       = r_error;
    assign o_last        = r_last;

endmodule
`default_nettype wire

// ===== rtl/awb_gain_register_writer.sv =====
`default_nettype none
// Channel   Handshake             Payload
// config    i_cfg_we              i_cfg_index, i_cfg_data
// input     start / busy          i_measured_red_ratio, i_measured_blue_ratio
// output    o_strobe (no stall)   o_reg_address, o_reg_data, o_error, o_last
//
// Pipeline: 1 input stage, 7 divider stages, 1 select stage, 7 divider stages,
// 1 select stage, then the write sequencer. Each item is written as nine
// beats by the sequencer; an error item is a single beat. Up to 4 items
// are in flight; busy holds off the next one. Synchronous active-low reset
// clears all valid/control state.
module awb_gain_register_writer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [awbg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [awbg_pkg::RATIO_W-1:0]         i_cfg_data,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [awbg_pkg::RATIO_W-1:0]         i_measured_red_ratio,
    input  wire logic [awbg_pkg::RATIO_W-1:0]         i_measured_blue_ratio,
    output logic                                      o_strobe,
    output logic [awbg_pkg::RATIO_W-1:0]              o_reg_address,
    output logic [awbg_pkg::BYTE_W-1:0]               o_reg_data,
    output logic                                      o_error,
    output logic                                      o_last
);

    localparam int N = awbg_pkg::DIV_STAGES;

    logic [awbg_pkg::RATIO_W-1:0] r_golden_red, r_golden_blue;
    logic [awbg_pkg::CNT_W-1:0]   r_count;
    logic                         accept, done;

    // stage 0
    logic                         r_s0_vld, r_s0_err;
    logic [awbg_pkg::RATIO_W-1:0] r_s0_mr, r_s0_mb, r_s0_gr, r_s0_gb;

    // phase A sideband
    logic                         r_a_vld [N];
    logic                         r_a_err [N];
    logic [awbg_pkg::RATIO_W-1:0] rr_q, br_q;

    // stage 1
    logic                         r_s1_vld, r_s1_err;
    logic [awbg_pkg::RATIO_W-1:0] r_s1_rr, r_s1_br;

    // phase B sideband
    logic                         r_b_vld [N];
    logic                         r_b_err [N];
    logic [awbg_pkg::RATIO_W-1:0] r_b_rr  [N];
    logic [awbg_pkg::RATIO_W-1:0] r_b_br  [N];
    logic [awbg_pkg::RATIO_W-1:0] q_rb, q_gb, q_gr, q_br;

    // stage 2
    logic                         r_s2_vld;
    awbg_pkg::t_gain_set          r_s2_set, n_s2_set;

    assign accept = start && !busy;
    assign busy   = (r_count == awbg_pkg::CNT_W'(awbg_pkg::FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_golden_red  <= awbg_pkg::RATIO_ONE;
            r_golden_blue <= awbg_pkg::RATIO_ONE;
            r_count       <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == awbg_pkg::CFG_GOLDEN_RED) begin
                r_golden_red <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == awbg_pkg::CFG_GOLDEN_BLUE) begin
                r_golden_blue <= i_cfg_data;
            end
            r_count <= r_count + {{(awbg_pkg::CNT_W-1){1'b0}}, accept}
                               - {{(awbg_pkg::CNT_W-1){1'b0}}, done};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_mr  <= i_measured_red_ratio;
        r_s0_mb  <= i_measured_blue_ratio;
        r_s0_gr  <= r_golden_red;
        r_s0_gb  <= r_golden_blue;
        r_s0_err <= (i_measured_red_ratio == '0) || (i_measured_blue_ratio == '0)
                 || (r_golden_red == '0) || (r_golden_blue == '0);
    end

    // phase A: 512*golden / measured
    awbg_div u_div_rr (
        .i_clk (i_clk),
        .i_num ({3'b000, r_s0_gr, 9'b0}),
        .i_den (r_s0_mr),
        .o_quo (rr_q)
    );
    awbg_div u_div_br (
        .i_clk (i_clk),
        .i_num ({3'b000, r_s0_gb, 9'b0}),
        .i_den (r_s0_mb),
        .o_quo (br_q)
    );

    always_ff @(posedge i_clk) begin
        r_a_err[0] <= r_s0_err;
        r_b_err[0] <= r_s1_err;
        r_b_rr[0]  <= r_s1_rr;
        r_b_br[0]  <= r_s1_br;
        for (int i = 1; i < N; i++) begin
            r_a_err[i] <= r_a_err[i-1];
            r_b_err[i] <= r_b_err[i-1];
            r_b_rr[i]  <= r_b_rr[i-1];
            r_b_br[i]  <= r_b_br[i-1];
        end
        r_s1_rr  <= rr_q;
        r_s1_br  <= br_q;
        r_s1_err <= r_a_err[N-1] || (rr_q == '0) || (br_q == '0);
        r_s2_set <= n_s2_set;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_a_vld[i] <= 1'b0;
                r_b_vld[i] <= 1'b0;
            end
        end else begin
            r_s0_vld   <= accept;
            r_a_vld[0] <= r_s0_vld;
            r_b_vld[0] <= r_s1_vld;
            for (int i = 1; i < N; i++) begin
                r_a_vld[i] <= r_a_vld[i-1];
                r_b_vld[i] <= r_b_vld[i-1];
            end
            r_s1_vld <= r_a_vld[N-1];
            r_s2_vld <= r_b_vld[N-1];
        end
    end

    // phase B: cross ratios and green gain candidates
    awbg_div u_div_rb (
        .i_clk (i_clk),
        .i_num ({4'b0000, r_s1_rr, 8'b0}),
        .i_den (r_s1_br),
        .o_quo (q_rb)
    );
    awbg_div u_div_gb (
        .i_clk (i_clk),
        .i_num (awbg_pkg::NUM_GAIN_ONE),
        .i_den (r_s1_br),
        .o_quo (q_gb)
    );
    awbg_div u_div_gr (
        .i_clk (i_clk),
        .i_num (awbg_pkg::NUM_GAIN_ONE),
        .i_den (r_s1_rr),
        .o_quo (q_gr)
    );
    awbg_div u_div_bq (
        .i_clk (i_clk),
        .i_num ({4'b0000, r_s1_br, 8'b0}),
        .i_den (r_s1_rr),
        .o_quo (q_br)
    );

    always_comb begin
        logic [awbg_pkg::RATIO_W-1:0] rr, br;
        logic                         hi_r, hi_b;
        rr   = r_b_rr[N-1];
        br   = r_b_br[N-1];
        hi_r = (rr >= awbg_pkg::RATIO_ONE);
        hi_b = (br >= awbg_pkg::RATIO_ONE);
        n_s2_set.err = r_b_err[N-1];
        if (hi_r && hi_b) begin
            // both at or above one: gains are ratio/2, green stays unity
            n_s2_set.red_gain   = {1'b0, rr[15:1]};
            n_s2_set.blue_gain  = {1'b0, br[15:1]};
            n_s2_set.green_gain = awbg_pkg::UNITY_GAIN;
        end else if (hi_r || (!hi_b && q_gr < q_gb)) begin
            n_s2_set.red_gain   = q_rb;
            n_s2_set.blue_gain  = awbg_pkg::UNITY_GAIN;
            n_s2_set.green_gain = q_gb;
        end else begin
            n_s2_set.red_gain   = awbg_pkg::UNITY_GAIN;
            n_s2_set.blue_gain  = q_br;
            n_s2_set.green_gain = q_gr;
        end
    end

    awbg_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (r_s2_vld),
        .i_set         (r_s2_set),
        .o_done        (done),
        .o_strobe      (o_strobe),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_error       (o_error),
        .o_last        (o_last)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= awbg_pkg::CNT_W'(awbg_pkg::FIFO_DEPTH))
        else $error("in-flight count overflow");

    a_done_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> r_count != '0)
        else $error("sequence finished with no item in flight");

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last without strobe");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_error |-> o_last && o_reg_address == '0 && o_reg_data == '0)
        else $error("error beat malformed");

endmodule
`default_nettype wire
